// ===== src/rnxarb_pkg.sv =====
// ----------------------------------------------------------------------------
// rnxarb_pkg
// Shared types and constants for the ring neighbor exclusion arbiter.
// ----------------------------------------------------------------------------
package rnxarb_pkg;

   // Ring geometry
   localparam int MAX_REQUESTERS = 32;
   localparam int IDX_W          = $clog2(MAX_REQUESTERS);
   localparam int SIZE_W         = IDX_W + 1;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_REQUESTERS);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

   // Input item opcode
   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // Per-seat state
   typedef enum logic [1:0] {
      SEAT_IDLE    = 2'd0,
      SEAT_WAITING = 2'd1,
      SEAT_GRANTED = 2'd2
   } seat_state_type;

   // Command broadcast to one cell for the accepted item
   typedef struct packed {
      logic release_op;  // item is a release
      logic is_self;     // this cell is the requester
      logic is_left;     // this cell is the requester's left neighbor
      logic is_right;    // this cell is the requester's right neighbor
   } cell_cmd_type;

   // What a cell shows its neighbors
   typedef struct packed {
      logic base;        // holds a grant, requester already seen as idle
      logic after_left;  // same, after the left retry of a release
   } cell_view_type;

   // Grants a cell gave for the accepted item
   typedef struct packed {
      logic self_g;
      logic left_g;
      logic right_g;
   } cell_grant_type;

endpackage

// ===== src/rnxarb_req_if.sv =====
// ----------------------------------------------------------------------------
// rnxarb_req_if
// Request channel: one request or release item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rnxarb_req_if;
   import rnxarb_pkg::*;

   logic             valid;
   logic             ready;
   logic             mode;
   logic [IDX_W-1:0] requester;

   modport source (output valid, output mode, output requester, input ready);
   modport sink   (input valid, input mode, input requester, output ready);
endinterface

// ===== src/rnxarb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rnxarb_rsp_if
// Result channel: grants caused by one item, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rnxarb_rsp_if;
   import rnxarb_pkg::*;

   logic             valid;
   logic             ready;
   logic             self_granted;
   logic             left_granted;
   logic [IDX_W-1:0] left_index;
   logic             right_granted;
   logic [IDX_W-1:0] right_index;
   logic             bad_index;

   modport source (output valid, output self_granted, output left_granted,
                   output left_index, output right_granted, output right_index,
                   output bad_index, input ready);
   modport sink   (input valid, input self_granted, input left_granted,
                   input left_index, input right_granted, input right_index,
                   input bad_index, output ready);
endinterface

// ===== src/rnxarb_cell.sv =====
// ----------------------------------------------------------------------------
// rnxarb_cell
// One seat of the ring: holds its state, looks at its two neighbors' views
// and applies the broadcast command.
// ----------------------------------------------------------------------------
module rnxarb_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  rnxarb_pkg::cell_cmd_type   cmd,
   input  rnxarb_pkg::cell_view_type  left_view,
   input  rnxarb_pkg::cell_view_type  right_view,
   output rnxarb_pkg::cell_view_type  view,
   output rnxarb_pkg::cell_grant_type grant
);
   import rnxarb_pkg::*;

   seat_state_type seat_ff;
   seat_state_type seat_in;
   logic           waiting;

   assign waiting = (seat_ff == SEAT_WAITING);

   // Grant decisions; the right retry sees the result of the left retry
   always_comb begin
      grant.self_g  = cmd.is_self && !cmd.release_op &&
                      !left_view.base && !right_view.base;
      grant.left_g  = cmd.is_left && cmd.release_op && waiting &&
                      !left_view.base && !right_view.base;
      grant.right_g = cmd.is_right && cmd.release_op && waiting && !grant.left_g &&
                      !left_view.after_left && !right_view.after_left;
   end

   // View shown to the neighbors
   always_comb begin
      view.base       = (seat_ff == SEAT_GRANTED) && !(cmd.is_self && cmd.release_op);
      view.after_left = view.base || grant.left_g;
   end

   // Next seat state
   always_comb begin
      seat_in = seat_ff;
      if (cmd.is_self) begin
         if (cmd.release_op) begin
            seat_in = SEAT_IDLE;
         end else if (grant.self_g) begin
            seat_in = SEAT_GRANTED;
         end else begin
            seat_in = SEAT_WAITING;
         end
      end else if (grant.left_g || grant.right_g) begin
         seat_in = SEAT_GRANTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seat_ff <= SEAT_IDLE;
      end else begin
         seat_ff <= seat_in;
      end
   end

endmodule

// ===== src/ring_neighbor_exclusion_arbiter.sv =====
// ----------------------------------------------------------------------------
// ring_neighbor_exclusion_arbiter
// Arbiter for a ring of requesters sharing one resource with each neighbor.
// ----------------------------------------------------------------------------
// Accepts one request or release item per clock while the result channel
// keeps up, and returns exactly one result item for it from an output
// register; a new item is taken while the previous result waits as long as
// that register drains in the same cycle. Each item updates the row of seat
// cells together: every cell decides from its own state and its two
// neighbors' views, so the clock period is set by the neighbor path from the
// left retry into the right retry. The ring size register is written through
// csr_wr_en/csr_wr_data, saturates to 2..32, and must only change while no
// item is in flight. Requester indices at or beyond the ring size change
// nothing and return only bad_index.
module ring_neighbor_exclusion_arbiter (
   input  logic                              clock,
   input  logic                              reset,
   rnxarb_req_if.sink                        req_chan,
   rnxarb_rsp_if.source                      rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rnxarb_pkg::SIZE_W-1:0]     csr_wr_data
);
   import rnxarb_pkg::*;

   logic [SIZE_W-1:0] ring_size_ff;
   logic [SIZE_W-1:0] size_used;
   logic [SIZE_W-1:0] size_m1;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  left_idx;
   logic [IDX_W-1:0]  right_idx;
   logic [SIZE_W-1:0] req_plus1;
   logic              bad;
   logic              accept;
   logic              apply;

   cell_cmd_type   cmd   [MAX_REQUESTERS];
   cell_view_type  view  [MAX_REQUESTERS];
   cell_view_type  lview [MAX_REQUESTERS];
   cell_view_type  rview [MAX_REQUESTERS];
   cell_grant_type grant [MAX_REQUESTERS];

   logic [MAX_REQUESTERS-1:0] self_vec;
   logic [MAX_REQUESTERS-1:0] left_vec;
   logic [MAX_REQUESTERS-1:0] right_vec;

   logic             rsp_valid_ff;
   logic             self_g_ff, self_g_in;
   logic             left_g_ff, left_g_in;
   logic [IDX_W-1:0] left_idx_ff, left_idx_in;
   logic             right_g_ff, right_g_in;
   logic [IDX_W-1:0] right_idx_ff, right_idx_in;
   logic             bad_ff, bad_in;

   // Ring size register
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         ring_size_ff <= csr_wr_data;
      end
   end

   // Saturated size and neighbor indices of the requester
   always_comb begin
      if (ring_size_ff < SIZE_MIN) begin
         size_used = SIZE_MIN;
      end else if (ring_size_ff > SIZE_MAX) begin
         size_used = SIZE_MAX;
      end else begin
         size_used = ring_size_ff;
      end
      size_m1   = size_used - SIZE_W'(1);
      last_idx  = size_m1[IDX_W-1:0];
      req_plus1 = {1'b0, req_chan.requester} + SIZE_W'(1);
      left_idx  = (req_chan.requester == '0) ? last_idx
                                              : req_chan.requester - IDX_W'(1);
      right_idx = (req_plus1 >= size_used) ? '0 : req_plus1[IDX_W-1:0];
      bad       = ({1'b0, req_chan.requester} >= size_used);
   end

   // Handshake: accept while the output register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign apply          = accept && !bad;

   // Row of seat cells, wrapped at the ring size
   for (genvar k = 0; k < MAX_REQUESTERS; k++) begin : g_cell
      always_comb begin
         cmd[k].release_op = (req_chan.mode == MODE_RELEASE);
         cmd[k].is_self    = apply && (req_chan.requester == IDX_W'(k));
         cmd[k].is_left    = apply && (left_idx == IDX_W'(k));
         cmd[k].is_right   = apply && (right_idx == IDX_W'(k));
      end

      if (k == 0) begin : g_first
         assign lview[k] = view[last_idx];
      end else begin : g_mid
         assign lview[k] = view[k-1];
      end

      if (k == MAX_REQUESTERS - 1) begin : g_end
         assign rview[k] = view[0];
      end else begin : g_next
         assign rview[k] = (last_idx == IDX_W'(k)) ? view[0] : view[k+1];
      end

      rnxarb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[k]),
         .left_view  (lview[k]),
         .right_view (rview[k]),
         .view       (view[k]),
         .grant      (grant[k])
      );

      assign self_vec[k]  = grant[k].self_g;
      assign left_vec[k]  = grant[k].left_g;
      assign right_vec[k] = grant[k].right_g;
   end

   // Result fields of the accepted item
   always_comb begin
      self_g_in    = |self_vec;
      left_g_in    = |left_vec;
      right_g_in   = |right_vec;
      left_idx_in  = bad ? '0 : left_idx;
      right_idx_in = bad ? '0 : right_idx;
      bad_in       = bad;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         self_g_ff    <= self_g_in;
         left_g_ff    <= left_g_in;
         left_idx_ff  <= left_idx_in;
         right_g_ff   <= right_g_in;
         right_idx_ff <= right_idx_in;
         bad_ff       <= bad_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.self_granted  = self_g_ff;
   assign rsp_chan.left_granted  = left_g_ff;
   assign rsp_chan.left_index    = left_idx_ff;
   assign rsp_chan.right_granted = right_g_ff;
   assign rsp_chan.right_index   = right_idx_ff;
   assign rsp_chan.bad_index     = bad_ff;

endmodule

// ===== tb/ring_neighbor_exclusion_arbiter_tb.sv =====
// ----------------------------------------------------------------------------
// ring_neighbor_exclusion_arbiter_tb
// Self-checking bench for the ring neighbor exclusion arbiter.
// ----------------------------------------------------------------------------
// A clocked driver feeds request/release items from a backlog queue, and a
// clocked receiver applies random back-pressure. Every accepted item runs
// through a local seat-state tracker that predicts the grant record it
// causes. Each returned record is checked against the oldest prediction.
// Phases step the ring size through its extremes and out-of-range values.
// ----------------------------------------------------------------------------
module ring_neighbor_exclusion_arbiter_tb;
   import rnxarb_pkg::*;

   // One request or release as queued for the driver
   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] who;
   } seat_cmd_type;

   // Grants reported for one item
   typedef struct packed {
      logic             self_g;
      logic             left_g;
      logic [IDX_W-1:0] left_idx;
      logic             right_g;
      logic [IDX_W-1:0] right_idx;
      logic             bad;
   } grant_rec_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   rnxarb_req_if req_if ();
   rnxarb_rsp_if rsp_if ();

   ring_neighbor_exclusion_arbiter dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   seat_cmd_type      cmd_backlog[$];
   grant_rec_type     grants_due[$];
   seat_state_type    seat_model[MAX_REQUESTERS];
   logic [SIZE_W-1:0] ring_cfg;
   bit                offer_busy = 1'b0;
   bit                calm       = 1'b0;
   int                tx_gap     = 0;
   int                rx_gap     = 0;
   int                hold_req   = 0;
   int                hold_seen  = 0;
   int                hold_left  = 0;
   int                failures   = 0;

   // Random phases: ring size written, then number of items
   int phase_size[9] = '{3, 32, 5, 2, 17, 1, 33, 8, 32};
   int phase_len[9]  = '{90, 130, 90, 70, 90, 50, 80, 90, 60};

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #(12 * 400000);
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Seat tracker
   // ---------------------------------------------------------------------

   // Ring size in use: register saturated to 2..MAX_REQUESTERS
   function automatic int unsigned ring_span();
      if (ring_cfg < SIZE_MIN) return 32'(SIZE_MIN);
      if (ring_cfg > SIZE_MAX) return 32'(SIZE_MAX);
      return 32'(ring_cfg);
   endfunction

   function automatic int unsigned left_seat(int unsigned i, int unsigned s);
      return (i == 0) ? s - 1 : i - 1;
   endfunction

   function automatic int unsigned right_seat(int unsigned i, int unsigned s);
      return (i + 1 >= s) ? 0 : i + 1;
   endfunction

   // A waiting seat takes the grant when neither neighbor holds one
   function automatic logic seat_try_grant(int unsigned i, int unsigned s);
      logic [IDX_W-1:0] at;
      logic [IDX_W-1:0] lt;
      logic [IDX_W-1:0] rt;
      at = IDX_W'(i);
      lt = IDX_W'(left_seat(i, s));
      rt = IDX_W'(right_seat(i, s));
      if (seat_model[at] == SEAT_WAITING &&
          seat_model[lt] != SEAT_GRANTED &&
          seat_model[rt] != SEAT_GRANTED) begin
         seat_model[at] = SEAT_GRANTED;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one item to the tracked seats and return the grants it gives
   function automatic grant_rec_type arbitrate(logic mode, logic [IDX_W-1:0] who);
      grant_rec_type g;
      int unsigned   s;
      int unsigned   l;
      int unsigned   r;
      g = '0;
      s = ring_span();
      if (32'(who) >= s) begin
         g.bad = 1'b1;
         return g;
      end
      l = left_seat(32'(who), s);
      r = right_seat(32'(who), s);
      if (mode == MODE_REQUEST) begin
         seat_model[who] = SEAT_WAITING;
         g.self_g = seat_try_grant(32'(who), s);
      end else begin
         seat_model[who] = SEAT_IDLE;
         // left retry first; in a ring of two the right retry sees its grant
         g.left_g  = seat_try_grant(l, s);
         g.right_g = seat_try_grant(r, s);
      end
      g.left_idx  = l[IDX_W-1:0];
      g.right_idx = r[IDX_W-1:0];
      return g;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (calm || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic void push_cmd(logic mode, int who);
      seat_cmd_type c;
      c.mode = mode;
      c.who  = IDX_W'(who);
      cmd_backlog.push_back(c);
   endfunction

   // Random items, mostly on seats inside the ring
   task automatic queue_random(int n);
      int who;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) who = $urandom_range(MAX_REQUESTERS - 1);
         else who = $urandom_range(ring_span() - 1);
         push_cmd($urandom_range(1) ? MODE_RELEASE : MODE_REQUEST, who);
      end
   endtask

   // Wait until every queued item is taken and its result checked
   task automatic drain();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || offer_busy || grants_due.size() != 0);
   endtask

   // Ring size write; only called with nothing in flight
   task automatic set_ring_size(int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SIZE_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      ring_cfg = SIZE_W'(value);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers backlog items at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      seat_cmd_type c;
      logic         launch;
      if (!reset && !offer_busy) begin
         launch = 1'b0;
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (cmd_backlog.size() != 0) begin
            c = cmd_backlog.pop_front();
            req_if.mode      <= c.mode;
            req_if.requester <= c.who;
            launch     = 1'b1;
            offer_busy = 1'b1;
            tx_gap     = pick_gap();
         end
         req_if.valid <= launch;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls plus one long hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rx_gap = pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Scoreboard: predict on input accept, check on result accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      grant_rec_type want;
      grant_rec_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            grants_due.push_back(arbitrate(req_if.mode, req_if.requester));
            offer_busy = 1'b0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.self_granted, rsp_if.left_granted, rsp_if.left_index,
                    rsp_if.right_granted, rsp_if.right_index, rsp_if.bad_index};
            if (grants_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result item with nothing pending: %p", $realtime, got);
            end else begin
               want = grants_due.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: mismatch exp self=%b left=%b/%0d right=%b/%0d bad=%b",
                              $realtime, want.self_g, want.left_g, want.left_idx,
                              want.right_g, want.right_idx, want.bad);
                     $display("%0t:          got self=%b left=%b/%0d right=%b/%0d bad=%b",
                              $realtime, got.self_g, got.left_g, got.left_idx,
                              got.right_g, got.right_idx, got.bad);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.mode      = MODE_REQUEST;
      req_if.requester = '0;
      rsp_if.ready     = 1'b0;
      ring_cfg         = SIZE_RESET;
      foreach (seat_model[k]) seat_model[k] = SEAT_IDLE;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Full ring at reset size: grants, blocking, re-request, release retries
      push_cmd(MODE_REQUEST, 0);
      push_cmd(MODE_REQUEST, 1);     // blocked by seat 0
      push_cmd(MODE_REQUEST, 31);    // blocked by seat 0 across the wrap
      push_cmd(MODE_REQUEST, 0);     // request while granted
      push_cmd(MODE_RELEASE, 0);     // grants both neighbors
      push_cmd(MODE_RELEASE, 5);     // release of an idle seat
      push_cmd(MODE_REQUEST, 2);
      push_cmd(MODE_RELEASE, 1);     // right neighbor takes over
      push_cmd(MODE_REQUEST, 30);
      push_cmd(MODE_RELEASE, 31);
      push_cmd(MODE_RELEASE, 2);
      push_cmd(MODE_RELEASE, 30);
      drain();

      // Ring of two: both neighbors are one seat; out-of-ring requesters
      set_ring_size(int'(SIZE_MIN));
      push_cmd(MODE_REQUEST, 0);
      push_cmd(MODE_REQUEST, 1);
      push_cmd(MODE_RELEASE, 0);     // left retry grants, right reports none
      push_cmd(MODE_REQUEST, 2);
      push_cmd(MODE_RELEASE, 31);
      push_cmd(MODE_RELEASE, 1);
      drain();

      // Ring size register out of range saturates
      set_ring_size(0);
      push_cmd(MODE_REQUEST, 1);
      push_cmd(MODE_REQUEST, 3);
      drain();
      set_ring_size(63);
      push_cmd(MODE_REQUEST, 31);
      push_cmd(MODE_RELEASE, 31);
      drain();

      // Random phases over several ring sizes
      for (int ph = 0; ph < 9; ph++) begin
         set_ring_size(phase_size[ph]);
         calm = (ph % 4 == 3);
         if (ph == 4) begin
            // sender stops halfway until every result is back
            queue_random(phase_len[ph] / 2);
            drain();
            queue_random(phase_len[ph] - phase_len[ph] / 2);
         end else begin
            queue_random(phase_len[ph]);
         end
         // long receiver hold-off while the backlog keeps offering
         if (ph == 1) hold_req++;
         drain();
      end

      repeat (8) @(negedge clock);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
